// ===== rtl/round_robin_scheduler_core_assert.svh =====
// Assertion macros for the round-robin scheduler core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTH
`define RRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("round robin scheduler check failed");
`define RRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("round robin scheduler check failed");
`else
`define RRS_ASSERT_IMP(lbl, ante, cons)
`define RRS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rrs_pkg.sv =====
// Shared types and constants for the round-robin scheduler core.
// No dependencies.
package rrs_pkg;

    localparam logic [23:0] TIME_MAX      = 24'hFF_FFFF;
    localparam logic [7:0]  QUANTUM_RESET = 8'd4;

    typedef struct packed {
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  process_index;
        logic [23:0] completion_time;
        logic [23:0] turnaround_time;
        logic [23:0] waiting_time;
        logic        final_result;
    } t_out_word;

    typedef enum logic [1:0] {
        AB_SEL_K   = 2'd0,
        AB_SEL_J   = 2'd1,
        AB_SEL_ORD = 2'd2
    } t_ab_sel;

    typedef struct packed {
        logic    load;
        logic    cnt_clr;
        logic    k_clr;
        logic    k_inc;
        logic    j_clr;
        logic    latch_ak;
        logic    rank_step;
        logic    j_inc;
        logic    ord_wr;
        logic    sim_init;
        logic    idx_latch;
        logic    adm_step;
        logic    pend_push;
        logic    jump_step;
        logic    pop;
        logic    slice;
        logic    out_ta;
        logic    out_load;
        t_ab_sel ab_sel;
    } t_cmd;

    typedef struct packed {
        logic k_last;
        logic j_last;
        logic ap_end;
        logic fifo_empty;
        logic arrived;
        logic bur_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/rrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rrs_datapath.sv =====
// Datapath: process tables, sort order, ready queue, clock and result register.
// Depends on rrs_pkg and rrs_ram.
module rrs_datapath import rrs_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  t_in_word  i_in_word,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  t_cmd      i_cmd,
    output t_sts      o_sts
);
    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_PROCS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);

    logic [7:0]    r_quantum;
    logic [CW-1:0] r_cnt, r_k, r_j, r_ap, r_fcnt;
    logic [IW-1:0] r_rank, r_idx, r_head, r_tail, r_p;
    logic [15:0]   r_ak, r_b;
    logic [23:0]   r_t, r_c, r_ta;
    logic          r_pend, r_pend_nz, r_ovalid;
    t_out_word     r_oword;

    logic [31:0]   ab_rdata;
    logic [15:0]   ab_arr, ab_bur, rem_rdata, run, rem_new;
    logic [23:0]   cmp_rdata, t_new, wait_v;
    logic [IW-1:0] ord_rdata, fifo_rdata, ab_raddr, head_nx, tail_nx;
    logic [7:0]    q;
    logic [24:0]   sum;
    logic          load_wr, push_adm, push_pend, push, less, tie;
    logic [CW+3:0] kx;

    assign ab_arr  = ab_rdata[31:16];
    assign ab_bur  = ab_rdata[15:0];
    assign load_wr = i_cmd.load && (r_cnt < MAX_CNT);

    // one quantum slice
    assign q       = (r_quantum == 8'd0) ? 8'd1 : r_quantum;
    assign run     = (rem_rdata < {8'd0, q}) ? rem_rdata : {8'd0, q};
    assign sum     = {1'b0, r_t} + {9'd0, run};
    assign t_new   = sum[24] ? TIME_MAX : sum[23:0];
    assign rem_new = rem_rdata - run;

    assign push_adm  = i_cmd.adm_step && (ab_bur != 16'd0);
    assign push_pend = i_cmd.pend_push && r_pend && r_pend_nz;
    assign push      = push_adm || push_pend;
    assign head_nx   = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_nx   = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;

    assign less = ab_arr < r_ak;
    assign tie  = (ab_arr == r_ak) && (r_j < r_k);

    assign wait_v = (r_ta > {8'd0, r_b}) ? r_ta - {8'd0, r_b} : 24'd0;
    assign kx     = {4'd0, r_k};

    always_comb begin
        case (i_cmd.ab_sel)
            AB_SEL_K:   ab_raddr = r_k[IW-1:0];
            AB_SEL_J:   ab_raddr = r_j[IW-1:0];
            AB_SEL_ORD: ab_raddr = ord_rdata;
            default:    ab_raddr = r_k[IW-1:0];
        endcase
    end

    rrs_ram #(.WIDTH(32), .DEPTH(MAX_PROCS)) u_ab_ram (
        .i_clk   (i_clk),
        .i_we    (load_wr),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata ({i_in_word.arrival_time, i_in_word.burst_time}),
        .i_raddr (ab_raddr),
        .o_rdata (ab_rdata)
    );

    rrs_ram #(.WIDTH(16), .DEPTH(MAX_PROCS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (load_wr || i_cmd.slice),
        .i_waddr (i_cmd.load ? r_cnt[IW-1:0] : r_p),
        .i_wdata (i_cmd.load ? i_in_word.burst_time : rem_new),
        .i_raddr (fifo_rdata),
        .o_rdata (rem_rdata)
    );

    rrs_ram #(.WIDTH(24), .DEPTH(MAX_PROCS)) u_cmp_ram (
        .i_clk   (i_clk),
        .i_we    (load_wr || (i_cmd.slice && rem_new == 16'd0)),
        .i_waddr (i_cmd.load ? r_cnt[IW-1:0] : r_p),
        .i_wdata (i_cmd.load ? {8'd0, i_in_word.arrival_time} : t_new),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (cmp_rdata)
    );

    rrs_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ord_wr),
        .i_waddr (r_rank),
        .i_wdata (r_k[IW-1:0]),
        .i_raddr (r_ap[IW-1:0]),
        .o_rdata (ord_rdata)
    );

    rrs_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata (push_adm ? r_idx : r_p),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
            r_cnt     <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_ap      <= '0;
            r_fcnt    <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_t       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
            if (load_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.sim_init) begin
                r_t    <= '0;
                r_ap   <= '0;
                r_head <= '0;
                r_tail <= '0;
                r_fcnt <= '0;
                r_pend <= 1'b0;
            end else begin
                if (i_cmd.adm_step || (i_cmd.jump_step && ab_bur == 16'd0)) begin
                    r_ap <= r_ap + 1'b1;
                end
                if (i_cmd.jump_step && ab_bur != 16'd0 && {8'd0, ab_arr} > r_t) begin
                    r_t <= {8'd0, ab_arr};
                end else if (i_cmd.slice) begin
                    r_t <= t_new;
                end
                if (push) begin
                    r_tail <= tail_nx;
                    r_fcnt <= r_fcnt + 1'b1;
                end else if (i_cmd.pop) begin
                    r_head <= head_nx;
                    r_fcnt <= r_fcnt - 1'b1;
                end
                if (i_cmd.slice) begin
                    r_pend <= 1'b1;
                end else if (i_cmd.pend_push) begin
                    r_pend <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_ak) begin
            r_ak   <= ab_arr;
            r_rank <= '0;
        end else if (i_cmd.rank_step && (less || tie)) begin
            r_rank <= r_rank + 1'b1;
        end
        if (i_cmd.idx_latch) begin
            r_idx <= ord_rdata;
        end
        if (i_cmd.pop) begin
            r_p <= fifo_rdata;
        end
        if (i_cmd.slice) begin
            r_pend_nz <= (rem_new != 16'd0);
        end
        if (i_cmd.out_ta) begin
            r_c  <= cmp_rdata;
            r_ta <= (cmp_rdata > {8'd0, ab_arr}) ? cmp_rdata - {8'd0, ab_arr} : 24'd0;
            r_b  <= ab_bur;
        end
        if (i_cmd.out_load) begin
            r_oword.process_index   <= kx[3:0];
            r_oword.completion_time <= r_c;
            r_oword.turnaround_time <= r_ta;
            r_oword.waiting_time    <= wait_v;
            r_oword.final_result    <= o_sts.k_last;
        end
    end

    assign o_sts.k_last     = ({1'b0, r_k} + 1'b1) == {1'b0, r_cnt};
    assign o_sts.j_last     = ({1'b0, r_j} + 1'b1) == {1'b0, r_cnt};
    assign o_sts.ap_end     = (r_ap == r_cnt);
    assign o_sts.fifo_empty = (r_fcnt == '0);
    assign o_sts.arrived    = ({8'd0, ab_arr} <= r_t);
    assign o_sts.bur_zero   = (ab_bur == 16'd0);
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
endmodule

// ===== rtl/rrs_ctrl.sv =====
// Controller state machine: load, sort, round-robin run and result drain.
// Depends on rrs_pkg.
module rrs_ctrl import rrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    typedef enum logic [16:0] {
        S_LOAD = 17'h00001,
        S_SK   = 17'h00002,
        S_SKW  = 17'h00004,
        S_SJ   = 17'h00008,
        S_SJW  = 17'h00010,
        S_SW   = 17'h00020,
        S_ADM  = 17'h00040,
        S_A1   = 17'h00080,
        S_A2   = 17'h00100,
        S_DISP = 17'h00200,
        S_J1   = 17'h00400,
        S_J2   = 17'h00800,
        S_P1   = 17'h01000,
        S_P2   = 17'h02000,
        S_OUT  = 17'h04000,
        S_O1   = 17'h08000,
        S_O2   = 17'h10000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_in_ready = (r_state == S_LOAD);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                o_cmd.load = acc;
                if (acc && i_last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_SK;
                end
            end
            S_SK: begin
                o_cmd.j_clr = 1'b1;
                n_state     = S_SKW;
            end
            S_SKW: begin
                o_cmd.latch_ak = 1'b1;
                n_state        = S_SJ;
            end
            S_SJ: begin
                o_cmd.ab_sel = AB_SEL_J;
                n_state      = S_SJW;
            end
            S_SJW: begin
                o_cmd.rank_step = 1'b1;
                o_cmd.j_inc     = 1'b1;
                n_state         = i_sts.j_last ? S_SW : S_SJ;
            end
            S_SW: begin
                o_cmd.ord_wr = 1'b1;
                o_cmd.k_inc  = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.sim_init = 1'b1;
                    n_state        = S_ADM;
                end else begin
                    n_state = S_SK;
                end
            end
            S_ADM: begin
                if (i_sts.ap_end) begin
                    o_cmd.pend_push = 1'b1;
                    n_state         = S_DISP;
                end else begin
                    n_state = S_A1;
                end
            end
            S_A1: begin
                o_cmd.ab_sel    = AB_SEL_ORD;
                o_cmd.idx_latch = 1'b1;
                n_state         = S_A2;
            end
            S_A2: begin
                if (i_sts.arrived) begin
                    o_cmd.adm_step = 1'b1;
                    n_state        = S_ADM;
                end else begin
                    o_cmd.pend_push = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.fifo_empty) begin
                    n_state = S_P1;
                end else if (i_sts.ap_end) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_J1;
                end
            end
            S_J1: begin
                o_cmd.ab_sel = AB_SEL_ORD;
                n_state      = S_J2;
            end
            S_J2: begin
                o_cmd.jump_step = 1'b1;
                n_state         = i_sts.bur_zero ? S_DISP : S_ADM;
            end
            S_P1: begin
                o_cmd.pop = 1'b1;
                n_state   = S_P2;
            end
            S_P2: begin
                o_cmd.slice = 1'b1;
                n_state     = S_ADM;
            end
            S_OUT: begin
                n_state = S_O1;
            end
            S_O1: begin
                o_cmd.out_ta = 1'b1;
                n_state      = S_O2;
            end
            S_O2: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.k_inc    = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/round_robin_scheduler_core.sv =====
// Top level of the round-robin scheduler core: controller plus datapath.
// Depends on rrs_pkg, rrs_ctrl, rrs_datapath and the assertion macro header.
//
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_ready   i_in_word  (t_in_word)
//  out       output     o_out_valid / i_out_ready o_out_word (t_out_word)
//  cfg       input      i_cfg_we (no wait)        i_cfg_data (quantum)
//
// Loading accepts one word per cycle. After the word with last set, the core sorts the
// set by arrival with a rank count through the table RAM. The run then pops the ready
// queue and gives each process a slice of up to one quantum, admitting processes that
// have arrived; when the queue is empty it jumps the clock to the next arrival. Results
// then leave through one output register, which an output stall can hold.
// Reset is synchronous and active low; the RAMs need no clearing pass.
`include "round_robin_scheduler_core_assert.svh"
module round_robin_scheduler_core import rrs_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word
);
    t_cmd cmd;
    t_sts sts;
    logic out_acc;
    logic times_ok;

    // sequencer: owns the input handshake and steps the datapath
    rrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_word.last),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // tables, ready queue, simulated clock and output register
    rrs_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign out_acc  = o_out_valid && i_out_ready;
    assign times_ok = (o_out_word.turnaround_time <= o_out_word.completion_time) &&
                      (o_out_word.waiting_time <= o_out_word.turnaround_time);

    // the final result leaves only once loading has reopened
    `RRS_ASSERT_IMP(a_final_reopens, out_acc && o_out_word.final_result, o_in_ready)
    // a last word closes the input for the run
    `RRS_ASSERT_NXT(a_last_closes, i_in_valid && o_in_ready && i_in_word.last, !o_in_ready)
    // times are ordered: waiting <= turnaround <= completion
    `RRS_ASSERT_IMP(a_time_order, o_out_valid, times_ok)
endmodule
